// ----- design/skf_pkg.sv -----
// shared types, constants and helper functions for the scalar kalman filter core
// no dependencies; skf_serial_mul, skf_serial_div, skf_seq and the core import this package
`timescale 1ns / 1ps

package skf_pkg;

  // fixed widths of the fixed-point fields
  localparam int unsigned DataW = 32;
  localparam int unsigned CoefW = 16;
  localparam int unsigned ProdW = 65;
  localparam int unsigned WideW = 66;
  localparam int unsigned NumW  = 55;
  localparam int unsigned DenW  = 47;
  localparam int unsigned CfgIdxW = 2;

  localparam logic signed [CoefW-1:0] ONE_Q8_8 = 16'sd256;
  localparam logic signed [WideW-1:0] ONE_Q8_24 = 66'sd16777216;
  localparam logic signed [WideW-1:0] S32_MAX_W = 66'sd2147483647;
  localparam logic signed [WideW-1:0] S32_MIN_W = -66'sd2147483648;
  localparam logic signed [WideW-1:0] U32_MAX_W = 66'sd4294967295;
  localparam logic [DataW-1:0] S32_MAX = 32'h7FFF_FFFF;
  localparam logic [DataW-1:0] S32_MIN = 32'h8000_0000;
  localparam logic [DataW-1:0] U32_MAX = 32'hFFFF_FFFF;

  // serial step counts (count runs down to zero)
  localparam logic [4:0] MUL_LAST_FULL = 5'd31;
  localparam logic [4:0] MUL_LAST_HALF = 5'd15;
  localparam logic [5:0] DIV_LAST      = 6'd54;

  typedef enum logic {
    OP_INIT    = 1'b0,
    OP_MEASURE = 1'b1
  } op_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_PROCESS_NOISE   = 2'd0,
    CFG_MEASURE_NOISE   = 2'd1,
    CFG_COEF_TRANSITION = 2'd2,
    CFG_COEF_OBSERVE    = 2'd3
  } cfg_idx_e;

  typedef enum logic [1:0] {
    MUL_IDLE,
    MUL_RUN,
    MUL_FIX
  } mul_state_e;

  typedef enum logic {
    DIV_IDLE,
    DIV_RUN
  } div_state_e;

  typedef enum logic [2:0] {
    SEQ_IDLE,
    SEQ_MUL_ISSUE,
    SEQ_MUL_WAIT,
    SEQ_DIV_WAIT,
    SEQ_DONE
  } seq_state_e;

  // multiply steps of one measurement, in order
  typedef enum logic [3:0] {
    MS_AX,   // a * x
    MS_AA,   // a * a
    MS_AAP,  // a*a * p
    MS_HH,   // h * h
    MS_HHP,  // h*h * p1
    MS_PH,   // p1 * |h|, numerator of the gain
    MS_HX,   // h * x1
    MS_GI,   // gain * innovation
    MS_GH,   // gain * h
    MS_FP    // factor * p1
  } step_e;

  typedef struct packed {
    logic [DataW-1:0]        process_noise;
    logic [DataW-1:0]        measure_noise;
    logic signed [CoefW-1:0] coef_transition;
    logic signed [CoefW-1:0] coef_observe;
  } skf_cfg_t;

  typedef struct packed {
    logic                    op;
    logic signed [DataW-1:0] sample_value;
    logic [DataW-1:0]        init_variance;
  } skf_cmd_t;

  typedef struct packed {
    logic signed [DataW-1:0] estimate;
    logic [DataW-1:0]        variance;
    logic                    saturated;
  } skf_res_t;

  typedef struct packed {
    logic             start;
    logic [DataW-1:0] mcand;
    logic [DataW-1:0] mplier;
    logic             neg;
    logic             half;
  } mul_req_t;

  typedef struct packed {
    logic                    done;
    logic signed [ProdW-1:0] prod;
  } mul_rsp_t;

  typedef struct packed {
    logic            start;
    logic [NumW-1:0] num;
    logic [DenW-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DataW-1:0] quo;
    logic             ovf;
  } div_rsp_t;

  typedef struct packed {
    logic             hit;
    logic [DataW-1:0] val;
  } sat_t;

  function automatic logic [DataW-1:0] abs16(input logic signed [CoefW-1:0] v);
    logic signed [CoefW:0] e;
    logic signed [CoefW:0] m;
    e = 17'(v);
    m = e[CoefW] ? -e : e;
    return {15'd0, m};
  endfunction

  function automatic logic [DataW-1:0] abs32(input logic signed [DataW-1:0] v);
    logic signed [DataW:0] e;
    logic signed [DataW:0] m;
    e = 33'(v);
    m = e[DataW] ? -e : e;
    return m[DataW-1:0];
  endfunction

  function automatic sat_t sat_s32(input logic signed [WideW-1:0] v);
    sat_t r;
    if (v > S32_MAX_W) begin
      r = '{hit: 1'b1, val: S32_MAX};
    end else if (v < S32_MIN_W) begin
      r = '{hit: 1'b1, val: S32_MIN};
    end else begin
      r = '{hit: 1'b0, val: v[DataW-1:0]};
    end
    return r;
  endfunction

  function automatic sat_t sat_u32(input logic signed [WideW-1:0] v);
    sat_t r;
    if (v < 0) begin
      r = '{hit: 1'b1, val: '0};
    end else if (v > U32_MAX_W) begin
      r = '{hit: 1'b1, val: U32_MAX};
    end else begin
      r = '{hit: 1'b0, val: v[DataW-1:0]};
    end
    return r;
  endfunction

  function automatic step_e next_step(input step_e s);
    step_e n;
    unique case (s)
      MS_AX:   n = MS_AA;
      MS_AA:   n = MS_AAP;
      MS_AAP:  n = MS_HH;
      MS_HH:   n = MS_HHP;
      MS_HHP:  n = MS_PH;
      MS_PH:   n = MS_HX;
      MS_HX:   n = MS_GI;
      MS_GI:   n = MS_GH;
      MS_GH:   n = MS_FP;
      MS_FP:   n = MS_AX;
      default: n = MS_AX;
    endcase
    return n;
  endfunction

endpackage

// ----- design/skf_in_if.sv -----
// sample channel: valid/ready handshake with op, sample value and initial variance
// no dependencies
`timescale 1ns / 1ps

interface skf_in_if;
  logic        valid;
  logic        ready;
  logic        op;
  logic signed [31:0] sample_value;
  logic [31:0] init_variance;

  modport source (output valid, op, sample_value, init_variance, input ready);
  modport sink   (input valid, op, sample_value, init_variance, output ready);
endinterface

// ----- design/skf_out_if.sv -----
// result channel: valid/ready handshake with estimate, variance and clamp flag
// no dependencies
`timescale 1ns / 1ps

interface skf_out_if;
  logic        valid;
  logic        ready;
  logic signed [31:0] estimate;
  logic [31:0] variance;
  logic        saturated;

  modport source (output valid, estimate, variance, saturated, input ready);
  modport sink   (input valid, estimate, variance, saturated, output ready);
endinterface

// ----- design/skf_serial_mul.sv -----
// bit-serial sign-magnitude multiplier, one multiplier bit per cycle
// depends on skf_pkg
`timescale 1ns / 1ps

module skf_serial_mul (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  skf_pkg::mul_req_t req_i,
  output skf_pkg::mul_rsp_t rsp_o
);
  import skf_pkg::*;

  mul_state_e state_q, state_d;
  logic load, step, fix;

  logic [2*DataW-1:0] acc_q;
  logic [DataW-1:0]   mcand_q, mplier_q;
  logic               neg_q, half_q;
  logic [4:0]         cnt_q;
  logic [DataW:0]     sum;
  logic [2*DataW-1:0] mag;
  logic signed [ProdW-1:0] prod_q;
  logic               done_q;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      MUL_IDLE: if (req_i.start) state_d = MUL_RUN;
      MUL_RUN:  if (cnt_q == '0) state_d = MUL_FIX;
      MUL_FIX:  state_d = MUL_IDLE;
      default:  state_d = MUL_IDLE;
    endcase
  end

  always_comb begin
    load = 1'b0;
    step = 1'b0;
    fix  = 1'b0;
    unique case (state_q)
      MUL_IDLE: load = req_i.start;
      MUL_RUN:  step = 1'b1;
      MUL_FIX:  fix  = 1'b1;
      default: ;
    endcase
  end

  // add the multiplicand into the upper half, then shift the whole accumulator right
  assign sum = {1'b0, acc_q[2*DataW-1:DataW]} + (mplier_q[0] ? {1'b0, mcand_q} : 33'd0);
  // a 16-bit multiplier leaves the product 16 places high
  assign mag = half_q ? {16'd0, acc_q[2*DataW-1:16]} : acc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= MUL_IDLE;
      cnt_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= fix;
      if (load) begin
        cnt_q <= req_i.half ? MUL_LAST_HALF : MUL_LAST_FULL;
      end else if (step) begin
        cnt_q <= cnt_q - 5'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      acc_q    <= '0;
      mcand_q  <= req_i.mcand;
      mplier_q <= req_i.mplier;
      neg_q    <= req_i.neg;
      half_q   <= req_i.half;
    end else if (step) begin
      acc_q    <= {sum, acc_q[DataW-1:1]};
      mplier_q <= {1'b0, mplier_q[DataW-1:1]};
    end
    if (fix) begin
      prod_q <= neg_q ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.prod = prod_q;

endmodule

// ----- design/skf_serial_div.sv -----
// restoring divider, one quotient bit per cycle, 32-bit quotient with overflow flag
// depends on skf_pkg
`timescale 1ns / 1ps

module skf_serial_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  skf_pkg::div_req_t req_i,
  output skf_pkg::div_rsp_t rsp_o
);
  import skf_pkg::*;

  div_state_e state_q, state_d;
  logic load, step;

  logic [NumW-1:0]  num_q;
  logic [DenW-1:0]  den_q;
  logic [DenW-1:0]  rem_q;
  logic [DataW-1:0] quo_q;
  logic             ovf_q;
  logic [5:0]       cnt_q;
  logic             done_q;
  logic [DenW:0]    rem_sh;
  logic [DenW+1:0]  diff;
  logic             ge;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      DIV_IDLE: if (req_i.start) state_d = DIV_RUN;
      DIV_RUN:  if (cnt_q == '0) state_d = DIV_IDLE;
      default:  state_d = DIV_IDLE;
    endcase
  end

  always_comb begin
    load = 1'b0;
    step = 1'b0;
    unique case (state_q)
      DIV_IDLE: load = req_i.start;
      DIV_RUN:  step = 1'b1;
      default: ;
    endcase
  end

  assign rem_sh = {rem_q, num_q[NumW-1]};
  assign diff   = {1'b0, rem_sh} - {2'b00, den_q};
  assign ge     = ~diff[DenW+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= DIV_IDLE;
      cnt_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= step && (cnt_q == '0);
      if (load) begin
        cnt_q <= DIV_LAST;
      end else if (step) begin
        cnt_q <= cnt_q - 6'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      num_q <= req_i.num;
      den_q <= req_i.den;
      rem_q <= '0;
      quo_q <= '0;
      ovf_q <= 1'b0;
    end else if (step) begin
      num_q <= {num_q[NumW-2:0], 1'b0};
      rem_q <= ge ? diff[DenW-1:0] : rem_sh[DenW-1:0];
      quo_q <= {quo_q[DataW-2:0], ge};
      // any quotient bit pushed out the top means the gain is out of range
      ovf_q <= ovf_q | quo_q[DataW-1];
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quo  = quo_q;
  assign rsp_o.ovf  = ovf_q;

endmodule

// ----- design/skf_seq.sv -----
// step sequencer and datapath: holds the filter state, drives the serial
// multiplier and divider and applies shifts and clamps; depends on skf_pkg
`timescale 1ns / 1ps

module skf_seq (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  skf_pkg::skf_cmd_t cmd_i,
  input  skf_pkg::skf_cfg_t cfg_i,
  input  logic              res_ready_i,
  output logic              idle_o,
  output logic              res_valid_o,
  output skf_pkg::skf_res_t res_o
);
  import skf_pkg::*;

  seq_state_e state_q, state_d;
  step_e      step_q, step_d;

  mul_req_t mul_req;
  mul_rsp_t mul_rsp;
  div_req_t div_req;
  div_rsp_t div_rsp;

  logic signed [DataW-1:0] x_q, z_q, x1_q, gain_q, innov_q, fac_q;
  logic [DataW-1:0]        p_q, p1_q, tmp_q;
  logic [DenW-1:0]         den_q;
  logic                    sat_q;
  logic                    den_nz;
  logic                    mul_wb, div_wb;

  logic signed [ProdW-1:0] prod;
  logic signed [WideW-1:0] prod_w, prod_sh8, prod_sh16;
  logic signed [WideW-1:0] aap_sum, hhp_sum, hx_diff, gi_sum, gh_shift;
  sat_t ax_s, aap_s, hx_s, gi_s, gh_s, fp_s, gain_s;
  logic wb_hit;

  logic signed [CoefW-1:0] coef_a, coef_h;

  assign coef_a = cfg_i.coef_transition;
  assign coef_h = cfg_i.coef_observe;
  assign den_nz = |den_q;
  assign mul_wb = (state_q == SEQ_MUL_WAIT) && mul_rsp.done;
  assign div_wb = (state_q == SEQ_DIV_WAIT) && div_rsp.done;

  skf_serial_mul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mul_req),
    .rsp_o  (mul_rsp)
  );

  skf_serial_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // next state
  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    unique case (state_q)
      SEQ_IDLE: begin
        if (start_i) begin
          state_d = (cmd_i.op == OP_MEASURE) ? SEQ_MUL_ISSUE : SEQ_DONE;
          step_d  = MS_AX;
        end
      end
      SEQ_MUL_ISSUE: state_d = SEQ_MUL_WAIT;
      SEQ_MUL_WAIT: begin
        if (mul_rsp.done) begin
          if (step_q == MS_FP) begin
            state_d = SEQ_DONE;
          end else if (step_q == MS_PH && den_nz) begin
            state_d = SEQ_DIV_WAIT;
          end else begin
            state_d = SEQ_MUL_ISSUE;
            step_d  = next_step(step_q);
          end
        end
      end
      SEQ_DIV_WAIT: begin
        if (div_rsp.done) begin
          state_d = SEQ_MUL_ISSUE;
          step_d  = next_step(step_q);
        end
      end
      SEQ_DONE: if (res_ready_i) state_d = SEQ_IDLE;
      default: state_d = SEQ_IDLE;
    endcase
  end

  // outputs: unit requests and handshake
  always_comb begin
    mul_req       = '0;
    mul_req.start = (state_q == SEQ_MUL_ISSUE);
    unique case (step_q)
      MS_AX: begin
        mul_req.mcand  = abs32(x_q);
        mul_req.mplier = abs16(coef_a);
        mul_req.neg    = x_q[DataW-1] ^ coef_a[CoefW-1];
        mul_req.half   = 1'b1;
      end
      MS_AA: begin
        mul_req.mcand  = abs16(coef_a);
        mul_req.mplier = abs16(coef_a);
        mul_req.half   = 1'b1;
      end
      MS_AAP: begin
        mul_req.mcand  = p_q;
        mul_req.mplier = tmp_q;
      end
      MS_HH: begin
        mul_req.mcand  = abs16(coef_h);
        mul_req.mplier = abs16(coef_h);
        mul_req.half   = 1'b1;
      end
      MS_HHP: begin
        mul_req.mcand  = p1_q;
        mul_req.mplier = tmp_q;
      end
      MS_PH: begin
        mul_req.mcand  = p1_q;
        mul_req.mplier = abs16(coef_h);
        mul_req.half   = 1'b1;
      end
      MS_HX: begin
        mul_req.mcand  = abs32(x1_q);
        mul_req.mplier = abs16(coef_h);
        mul_req.neg    = x1_q[DataW-1] ^ coef_h[CoefW-1];
        mul_req.half   = 1'b1;
      end
      MS_GI: begin
        mul_req.mcand  = abs32(gain_q);
        mul_req.mplier = abs32(innov_q);
        mul_req.neg    = gain_q[DataW-1] ^ innov_q[DataW-1];
      end
      MS_GH: begin
        mul_req.mcand  = abs32(gain_q);
        mul_req.mplier = abs16(coef_h);
        mul_req.neg    = gain_q[DataW-1] ^ coef_h[CoefW-1];
        mul_req.half   = 1'b1;
      end
      MS_FP: begin
        mul_req.mcand  = abs32(fac_q);
        mul_req.mplier = p1_q;
        mul_req.neg    = fac_q[DataW-1];
      end
      default: ;
    endcase

    // numerator is p1 * |h| * 256; the sign of h is applied to the quotient
    div_req.start = mul_wb && (step_q == MS_PH) && den_nz;
    div_req.num   = {mul_rsp.prod[DenW-1:0], 8'd0};
    div_req.den   = den_q;

    idle_o      = (state_q == SEQ_IDLE);
    res_valid_o = (state_q == SEQ_DONE);
  end

  // shifts, sums and clamps on the registered product
  always_comb begin
    prod      = mul_rsp.prod;
    prod_w    = 66'(prod);
    prod_sh8  = prod_w >>> 8;
    prod_sh16 = prod_w >>> 16;
    aap_sum   = prod_sh16 + $signed({34'd0, cfg_i.process_noise});
    hhp_sum   = prod_sh16 + $signed({34'd0, cfg_i.measure_noise});
    hx_diff   = 66'(z_q) - prod_sh8;
    gi_sum    = 66'(x1_q) + prod_sh16;
    gh_shift  = (ONE_Q8_24 - prod_w) >>> 8;

    ax_s  = sat_s32(prod_sh8);
    aap_s = sat_u32(aap_sum);
    hx_s  = sat_s32(hx_diff);
    gi_s  = sat_s32(gi_sum);
    gh_s  = sat_s32(gh_shift);
    fp_s  = sat_u32(prod_sh16);

    unique case (step_q)
      MS_AX:   wb_hit = ax_s.hit;
      MS_AAP:  wb_hit = aap_s.hit;
      MS_HX:   wb_hit = hx_s.hit;
      MS_GI:   wb_hit = gi_s.hit;
      MS_GH:   wb_hit = gh_s.hit;
      MS_FP:   wb_hit = fp_s.hit;
      default: wb_hit = 1'b0;
    endcase

    // gain from the quotient magnitude, truncated toward zero
    if (coef_h[CoefW-1]) begin
      gain_s.hit = div_rsp.ovf | (div_rsp.quo[DataW-1] & (|div_rsp.quo[DataW-2:0]));
      gain_s.val = gain_s.hit ? S32_MIN : -div_rsp.quo;
    end else begin
      gain_s.hit = div_rsp.ovf | div_rsp.quo[DataW-1];
      gain_s.val = gain_s.hit ? S32_MAX : div_rsp.quo;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SEQ_IDLE;
      step_q  <= MS_AX;
      sat_q   <= 1'b0;
      x_q     <= '0;
      p_q     <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      if (state_q == SEQ_IDLE && start_i) begin
        sat_q <= 1'b0;
        if (cmd_i.op == OP_INIT) begin
          x_q <= cmd_i.sample_value;
          p_q <= cmd_i.init_variance;
        end
      end
      if (mul_wb) begin
        sat_q <= sat_q | wb_hit;
        if (step_q == MS_GI) x_q <= gi_s.val;
        if (step_q == MS_FP) p_q <= fp_s.val;
      end
      if (div_wb) begin
        sat_q <= sat_q | gain_s.hit;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == SEQ_IDLE && start_i) begin
      z_q <= cmd_i.sample_value;
    end
    if (mul_wb) begin
      unique case (step_q)
        MS_AX:         x1_q    <= ax_s.val;
        MS_AA, MS_HH:  tmp_q   <= prod[DataW-1:0];
        MS_AAP:        p1_q    <= aap_s.val;
        MS_HHP:        den_q   <= hhp_sum[DenW-1:0];
        MS_PH:         if (!den_nz) gain_q <= '0;
        MS_HX:         innov_q <= hx_s.val;
        MS_GH:         fac_q   <= gh_s.val;
        default: ;
      endcase
    end
    if (div_wb) begin
      gain_q <= gain_s.val;
    end
  end

  assign res_o.estimate  = x_q;
  assign res_o.variance  = p_q;
  assign res_o.saturated = sat_q;

endmodule

// ----- design/scalar_kalman_filter_core.sv -----
// top level of the scalar kalman filter: configuration registers, input
// handshake and output register; depends on skf_pkg, skf_in_if, skf_out_if, skf_seq
`timescale 1ns / 1ps

// usage
//   smp_i is the sample channel: op 0 loads the estimate and variance from
//   sample_value and init_variance and sets both coefficients back to one;
//   op 1 runs one predict and update step with sample_value as the measurement.
//   res_o returns one transaction per sample transaction: the estimate and
//   variance that now stand and a flag that is set when any value was clamped.
//   cfg_we_i/cfg_idx_i/cfg_wdata_i write q, r, the transition coefficient and
//   the observation coefficient (indexes 0 to 3); coefficients take data bits 15:0.
// flow
//   an init transaction passes through the sequencer's done state and then the
//   output register on its way to res_o. a measurement runs ten serial multiplies,
//   each on a 16-bit or a 32-bit multiplier, plus the bit-serial restoring divider
//   for the gain, which is skipped when the gain denominator is zero.
//   the sequencer works on one transaction at a time; smp_i.ready is high while
//   it is idle, also while a finished result still sits in the output register.
// reset
//   rst_ni clears the estimate and variance to zero, loads q = 655, r = 65536
//   and both coefficients to one, and empties the output register.
// stall
//   while res_o is stalled the result is held; the next transaction is taken
//   and computed, and it waits in the sequencer until the output register frees.
module scalar_kalman_filter_core (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  skf_in_if.sink                       smp_i,
  skf_out_if.source                    res_o,
  input  logic                         cfg_we_i,
  input  logic [skf_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [skf_pkg::DataW-1:0]    cfg_wdata_i
);
  import skf_pkg::*;

  skf_cfg_t cfg_q;
  skf_cmd_t cmd;
  skf_res_t seq_res;
  skf_res_t out_res_q;
  logic     out_valid_q;
  logic     seq_idle;
  logic     seq_res_valid;
  logic     seq_res_ready;
  logic     accept;

  // a sample transaction is taken whenever the sequencer is idle
  assign smp_i.ready = seq_idle;
  assign accept      = smp_i.valid & smp_i.ready;

  always_comb begin
    cmd.op            = smp_i.op;
    cmd.sample_value  = smp_i.sample_value;
    cmd.init_variance = smp_i.init_variance;
  end

  // configuration registers; an init transaction restores unit coefficients
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.process_noise   <= 32'd655;
      cfg_q.measure_noise   <= 32'd65536;
      cfg_q.coef_transition <= ONE_Q8_8;
      cfg_q.coef_observe    <= ONE_Q8_8;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_e'(cfg_idx_i))
          CFG_PROCESS_NOISE:   cfg_q.process_noise   <= cfg_wdata_i;
          CFG_MEASURE_NOISE:   cfg_q.measure_noise   <= cfg_wdata_i;
          CFG_COEF_TRANSITION: cfg_q.coef_transition <= $signed(cfg_wdata_i[CoefW-1:0]);
          CFG_COEF_OBSERVE:    cfg_q.coef_observe    <= $signed(cfg_wdata_i[CoefW-1:0]);
        endcase
      end
      if (accept && smp_i.op == OP_INIT) begin
        cfg_q.coef_transition <= ONE_Q8_8;
        cfg_q.coef_observe    <= ONE_Q8_8;
      end
    end
  end

  skf_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (accept),
    .cmd_i       (cmd),
    .cfg_i       (cfg_q),
    .res_ready_i (seq_res_ready),
    .idle_o      (seq_idle),
    .res_valid_o (seq_res_valid),
    .res_o       (seq_res)
  );

  // output register: the sequencer hands over when the slot is empty or draining
  assign seq_res_ready = ~out_valid_q | res_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (seq_res_valid && seq_res_ready) begin
      out_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (seq_res_valid && seq_res_ready) begin
      out_res_q <= seq_res;
    end
  end

  assign res_o.valid     = out_valid_q;
  assign res_o.estimate  = out_res_q.estimate;
  assign res_o.variance  = out_res_q.variance;
  assign res_o.saturated = out_res_q.saturated;

endmodule

// ----- sim/skf_checker.sv -----
// result checker for the scalar kalman filter core: watches both channels and the
// config port, predicts each result and compares; depends on skf_pkg, skf_in_if, skf_out_if
`timescale 1ns / 1ps

module skf_checker (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  skf_in_if                           smp_i,
  skf_out_if                          res_i,
  input  logic                        cfg_we_i,
  input  logic [skf_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [skf_pkg::DataW-1:0]   cfg_wdata_i,
  output int unsigned                 fail_cnt_o,
  output int unsigned                 pending_o
);

  import skf_pkg::*;

  localparam longint S32_HI    = 64'sd2147483647;
  localparam longint S32_LO    = -64'sd2147483648;
  localparam longint U32_HI    = 64'sd4294967295;
  localparam longint UNITY_Q24 = 64'sd16777216;
  localparam longint Q_RESET   = 64'sd655;
  localparam longint R_RESET   = 64'sd65536;
  localparam int unsigned MAX_REPORTS = 10;

  // filter state and register copies, all held as 64-bit signed values
  longint q_noise, r_noise, coef_a, coef_h;
  longint est_x, var_p;

  skf_res_t    expected_q[$];
  skf_res_t    exp_res;
  skf_res_t    got_res;
  int unsigned fails;
  int unsigned reported;

  function automatic longint clamp_s32(input longint v);
    if (v > S32_HI) return S32_HI;
    if (v < S32_LO) return S32_LO;
    return v;
  endfunction

  function automatic longint clamp_u32(input longint v);
    if (v < 0) return 0;
    if (v > U32_HI) return U32_HI;
    return v;
  endfunction

  // one filter step; >>> on signed operands floors, / truncates toward zero
  task automatic filter_step(input logic op, input logic signed [31:0] z_in,
                             input logic [31:0] pv_in, output skf_res_t res);
    longint z, t, x1, p1, den, gain, innov, fac;
    logic   hit;
    hit = 1'b0;
    z   = longint'(z_in);
    if (op_e'(op) == OP_INIT) begin
      est_x  = z;
      var_p  = longint'({32'd0, pv_in});
      coef_a = longint'(ONE_Q8_8);
      coef_h = longint'(ONE_Q8_8);
    end else begin
      t  = (coef_a * est_x) >>> 8;
      x1 = clamp_s32(t);
      hit |= (x1 != t);
      t  = ((coef_a * coef_a * var_p) >>> 16) + q_noise;
      p1 = clamp_u32(t);
      hit |= (p1 != t);
      den = ((coef_h * coef_h * p1) >>> 16) + r_noise;
      if (den == 0) begin
        gain = 0;
      end else begin
        t    = ((p1 * coef_h) <<< 8) / den;
        gain = clamp_s32(t);
        hit |= (gain != t);
      end
      t     = z - ((coef_h * x1) >>> 8);
      innov = clamp_s32(t);
      hit |= (innov != t);
      t     = x1 + ((gain * innov) >>> 16);
      est_x = clamp_s32(t);
      hit |= (est_x != t);
      t   = (UNITY_Q24 - gain * coef_h) >>> 8;
      fac = clamp_s32(t);
      hit |= (fac != t);
      t     = (fac * p1) >>> 16;
      var_p = clamp_u32(t);
      hit |= (var_p != t);
    end
    res.estimate  = est_x[31:0];
    res.variance  = var_p[31:0];
    res.saturated = hit;
  endtask

  task automatic note_failure(input string msg);
    fails++;
    if (reported < MAX_REPORTS) begin
      reported++;
      $display("%t skf_checker: %s", $realtime, msg);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      q_noise  = Q_RESET;
      r_noise  = R_RESET;
      coef_a   = longint'(ONE_Q8_8);
      coef_h   = longint'(ONE_Q8_8);
      est_x    = 0;
      var_p    = 0;
      fails    = 0;
      reported = 0;
      expected_q.delete();
      fail_cnt_o <= 0;
      pending_o  <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_PROCESS_NOISE:   q_noise = longint'({32'd0, cfg_wdata_i});
          CFG_MEASURE_NOISE:   r_noise = longint'({32'd0, cfg_wdata_i});
          CFG_COEF_TRANSITION: coef_a  = longint'($signed(cfg_wdata_i[15:0]));
          CFG_COEF_OBSERVE:    coef_h  = longint'($signed(cfg_wdata_i[15:0]));
          default: ;
        endcase
      end
      if (smp_i.valid && smp_i.ready) begin
        filter_step(smp_i.op, smp_i.sample_value, smp_i.init_variance, exp_res);
        expected_q.push_back(exp_res);
      end
      if (res_i.valid && res_i.ready) begin
        got_res.estimate  = res_i.estimate;
        got_res.variance  = res_i.variance;
        got_res.saturated = res_i.saturated;
        if (expected_q.size() == 0) begin
          note_failure($sformatf("result with nothing pending: est %h var %h sat %b",
                                 got_res.estimate, got_res.variance, got_res.saturated));
        end else begin
          exp_res = expected_q.pop_front();
          if (got_res.estimate !== exp_res.estimate) begin
            note_failure($sformatf("estimate exp %h got %h",
                                   exp_res.estimate, got_res.estimate));
          end
          if (got_res.variance !== exp_res.variance) begin
            note_failure($sformatf("variance exp %h got %h",
                                   exp_res.variance, got_res.variance));
          end
          if (got_res.saturated !== exp_res.saturated) begin
            note_failure($sformatf("saturated exp %b got %b",
                                   exp_res.saturated, got_res.saturated));
          end
        end
      end
      fail_cnt_o <= fails;
      pending_o  <= expected_q.size();
    end
  end

endmodule

// ----- sim/scalar_kalman_filter_core_tb.sv -----
// testbench top for the scalar kalman filter core: clock, reset, sample and config
// stimulus, result sink and verdict; depends on skf_pkg, the channel interfaces, skf_checker
`timescale 1ns / 1ps

module scalar_kalman_filter_core_tb;

  import skf_pkg::*;

  localparam int unsigned RAND_ITEMS  = 1350;
  localparam int unsigned CYCLE_LIMIT = 2_000_000;
  // quiet time at the end, longer than one measurement
  localparam int unsigned TAIL_CYCLES = 400;

  logic               clk;
  logic               rst_n;
  logic               cfg_we;
  logic [CfgIdxW-1:0] cfg_idx;
  logic [DataW-1:0]   cfg_wdata;
  int unsigned        fail_cnt;
  int unsigned        pending;
  int unsigned        cycle_cnt;
  // phase flags: when set that side never idles
  bit                 src_calm;
  bit                 sink_calm;

  skf_in_if  smp ();
  skf_out_if res ();

  scalar_kalman_filter_core i_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .smp_i       (smp),
    .res_o       (res),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata)
  );

  skf_checker i_checker (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .smp_i       (smp),
    .res_i       (res),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .fail_cnt_o  (fail_cnt),
    .pending_o   (pending)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  // random field values, weighted toward extremes and realistic small values
  function automatic logic [31:0] rand_sample();
    case ($urandom_range(0, 9))
      0:          return S32_MIN;
      1:          return S32_MAX;
      2, 3, 4, 5: return $urandom_range(0, 32'h0080_0000) - 32'h0040_0000;
      default:    return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] rand_variance();
    case ($urandom_range(0, 9))
      0:          return '0;
      1:          return U32_MAX;
      2, 3, 4, 5: return $urandom_range(0, 32'h0040_0000);
      default:    return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] rand_noise();
    case ($urandom_range(0, 9))
      0:          return '0;
      1:          return U32_MAX;
      2, 3, 4, 5: return $urandom_range(0, 32'h0010_0000);
      default:    return $urandom;
    endcase
  endfunction

  // coefficients in q8.8, close to one half of the time, else extremes, zero or random
  function automatic logic [15:0] rand_coef();
    case ($urandom_range(0, 9))
      0:             return 16'h8000;
      1:             return 16'h7FFF;
      2:             return 16'h0000;
      3, 4, 5, 6, 7: return 16'($urandom_range(192, 320));
      default:       return 16'($urandom);
    endcase
  endfunction

  // one sample transaction; valid stays high after acceptance so that a
  // back-to-back item never drops it within the same step
  task automatic send_sample(input op_e op, input logic [31:0] z, input logic [31:0] pv);
    int unsigned gap;
    bit          hold;
    gap  = src_calm ? 0 : $urandom_range(0, 8);
    hold = !src_calm && ($urandom_range(0, 1) == 1);
    if (hold) begin
      // wait until the core is free, then idle a little more
      smp.valid <= 1'b0;
      do @(posedge clk); while (!smp.ready);
      repeat (gap) @(posedge clk);
    end else if (gap != 0) begin
      smp.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    smp.valid         <= 1'b1;
    smp.op            <= op;
    smp.sample_value  <= z;
    smp.init_variance <= pv;
    do @(posedge clk); while (!smp.ready);
  endtask

  // stop sending and wait until every expected result has come back
  task automatic drain_results();
    smp.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  // write all four registers on consecutive edges; upper coefficient bits are junk
  task automatic load_config(input logic [31:0] q, input logic [31:0] r,
                             input logic [15:0] a, input logic [15:0] h);
    cfg_we    <= 1'b1;
    cfg_idx   <= CFG_PROCESS_NOISE;
    cfg_wdata <= q;
    @(posedge clk);
    cfg_idx   <= CFG_MEASURE_NOISE;
    cfg_wdata <= r;
    @(posedge clk);
    cfg_idx   <= CFG_COEF_TRANSITION;
    cfg_wdata <= {16'($urandom), a};
    @(posedge clk);
    cfg_idx   <= CFG_COEF_OBSERVE;
    cfg_wdata <= {16'($urandom), h};
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // result sink: after each transaction it may hold ready low, then waits for
  // the next result to show up and keeps it stalled for a few more cycles
  initial begin : result_sink
    int unsigned stall;
    res.ready <= 1'b1;
    forever begin
      do @(posedge clk); while (!(res.valid && res.ready));
      stall = sink_calm ? 0 : $urandom_range(0, 8);
      if (stall != 0) begin
        res.ready <= 1'b0;
        do @(posedge clk); while (!res.valid);
        repeat (stall) @(posedge clk);
        res.ready <= 1'b1;
      end
    end
  end

  // cycle counter that ends a hung run
  initial begin : watchdog
    cycle_cnt = 0;
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("scalar_kalman_filter_core_tb: done, errors");
    $finish;
  end

  initial begin : stimulus
    int unsigned sent;
    int unsigned phase_len;
    int unsigned i;
    sent      = 0;
    src_calm  = 1'b0;
    sink_calm = 1'b0;
    rst_n             <= 1'b0;
    cfg_we            <= 1'b0;
    cfg_idx           <= CFG_PROCESS_NOISE;
    cfg_wdata         <= '0;
    smp.valid         <= 1'b0;
    smp.op            <= OP_INIT;
    smp.sample_value  <= '0;
    smp.init_variance <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: reset settings, measurement on the cleared state
    send_sample(OP_MEASURE, 32'h0001_0000, $urandom);
    send_sample(OP_INIT, 32'h0005_0000, 32'h0002_0000);
    send_sample(OP_MEASURE, 32'h0004_8000, $urandom);
    // measurements at both ends of the sample range
    send_sample(OP_MEASURE, S32_MAX, $urandom);
    send_sample(OP_MEASURE, S32_MIN, $urandom);
    // predicted variance overflows, estimate at its extremes
    send_sample(OP_INIT, S32_MAX, U32_MAX);
    send_sample(OP_MEASURE, S32_MIN, $urandom);
    send_sample(OP_INIT, S32_MIN, '0);
    send_sample(OP_MEASURE, S32_MAX, $urandom);
    drain_results();

    // largest noise, coefficients at opposite extremes
    load_config(U32_MAX, U32_MAX, 16'h8000, 16'h7FFF);
    send_sample(OP_MEASURE, S32_MAX, $urandom);
    send_sample(OP_MEASURE, '0, $urandom);
    drain_results();
    load_config(32'h0000_0001, 32'h0000_0001, 16'h7FFF, 16'h8000);
    send_sample(OP_MEASURE, S32_MIN, $urandom);
    // init puts both coefficients back to one
    send_sample(OP_INIT, 32'hFFFF_0000, 32'h0001_0000);
    send_sample(OP_MEASURE, 32'h0000_8000, $urandom);
    drain_results();

    // zero denominator: no noise and zero coefficients give a zero gain
    load_config('0, '0, 16'h0000, 16'h0000);
    send_sample(OP_MEASURE, 32'h1234_5678, $urandom);
    send_sample(OP_MEASURE, 32'hEDCB_A988, $urandom);
    // gain above one over h drives the new variance negative
    send_sample(OP_INIT, 32'h0001_0000, 32'h0001_0001);
    drain_results();
    load_config('0, '0, 16'h0100, 16'h0001);
    send_sample(OP_MEASURE, 32'h0002_0000, $urandom);
    send_sample(OP_MEASURE, 32'hFFFE_0000, $urandom);
    drain_results();

    // random phases: fresh settings, mostly an init followed by measurements
    while (sent < RAND_ITEMS) begin
      drain_results();
      load_config(rand_noise(), rand_noise(), rand_coef(), rand_coef());
      src_calm  = ($urandom_range(0, 3) == 0);
      sink_calm = ($urandom_range(0, 3) == 0);
      phase_len = $urandom_range(20, 60);
      if ($urandom_range(0, 3) != 0) begin
        send_sample(OP_INIT, rand_sample(), rand_variance());
        sent++;
      end
      for (i = 0; i < phase_len; i++) begin
        if ($urandom_range(0, 9) == 0) begin
          send_sample(OP_INIT, rand_sample(), rand_variance());
        end else begin
          send_sample(OP_MEASURE, rand_sample(), $urandom);
        end
        sent++;
      end
    end

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_cnt == 0 && pending == 0) begin
      $display("scalar_kalman_filter_core_tb: done, clean");
    end else begin
      $display("scalar_kalman_filter_core_tb: done, errors");
    end
    $finish;
  end

endmodule
